FILE: rtl/pfst_pkg.sv
// Shared types, constants and angle helpers for the polar free-space table.
// Used by every module of the block except pfst_ram; depends on nothing.
package pfst_pkg;

   localparam int NUM_SLOTS = 32;
   localparam int FRAC_BITS = 6;

   localparam int SLOT_W      = $clog2(NUM_SLOTS);
   localparam int IDX_W       = 6;
   localparam int DIST_W      = 16;
   localparam int ANGLE_W     = 13;
   localparam int ANGLE_U_W   = ANGLE_W - 1;
   localparam int OPCODE_W    = 3;
   localparam int RES_SLOT_W  = 5;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 24;

   localparam int ANGLE_MAX   = NUM_SLOTS << FRAC_BITS;
   localparam int MAX_W       = $clog2(ANGLE_MAX + 1);
   localparam int CMP_W       = (MAX_W > ANGLE_U_W) ? MAX_W : ANGLE_U_W;

   localparam int SAMPLES     = 10;
   localparam int DIVISOR     = 10;
   localparam int CNT_W       = $clog2(SAMPLES);
   localparam int REM_W       = $clog2(DIVISOR);
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = 16;
   localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR);
   localparam int PROD_W      = ANGLE_U_W + RECIP_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DIST_W-1:0] DIST_RESET = '1;

   localparam logic [OPCODE_W-1:0] OP_WRITE  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_READ   = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_SEARCH = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_OCCUPY = 3'd4;

   typedef enum logic [2:0] {
      K_NONE,
      K_WRITE,
      K_READ,
      K_CLEAR,
      K_SEARCH,
      K_OCCUPY
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic                    bad;
      logic [SLOT_W-1:0]       slot_lo;
      logic [SLOT_W-1:0]       slot_hi;
      logic [ANGLE_U_W-1:0]    angle;
      logic [ANGLE_U_W-1:0]    q0;
      logic [REM_W-1:0]        r0;
      logic [DIST_W-1:0]       distance;
      logic [DIST_W-1:0]       threshold;
   } cmd_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_EXEC,
      B_SCAN,
      B_DRAIN,
      B_DONE
   } back_state_type;

   function automatic logic angle_ok(input logic signed [ANGLE_W-1:0] a);
      logic [CMP_W-1:0] mag;
      mag = CMP_W'(a[ANGLE_U_W-1:0]);
      return !a[ANGLE_W-1] && (mag <= CMP_W'(ANGLE_MAX));
   endfunction

   // boundary angles fall into the lower slot
   function automatic logic [SLOT_W-1:0] angle_slot(input logic [ANGLE_U_W-1:0] a);
      logic [ANGLE_U_W-1:0] am1;
      am1 = a - ANGLE_U_W'(1);
      if (a == '0) begin
         return '0;
      end
      return SLOT_W'(am1 >> FRAC_BITS);
   endfunction

endpackage

FILE: rtl/pfst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module pfst_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pfst_front.sv
// Front end: accepts requests, checks arguments and classifies each into a command.
// Uses pfst_pkg types and angle helpers; feeds pfst_fifo.
module pfst_front (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pfst_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [pfst_pkg::OPCODE_W-1:0]   req_tuser,
   input  logic                            queue_full,
   output logic                            push,
   output pfst_pkg::cmd_type               cmd
);

   logic [pfst_pkg::OPCODE_W-1:0]         opcode;
   logic [pfst_pkg::IDX_W-1:0]            slot_index;
   logic [pfst_pkg::DIST_W-1:0]           distance_value;
   logic signed [pfst_pkg::ANGLE_W-1:0]   start_angle;
   logic signed [pfst_pkg::ANGLE_W-1:0]   end_angle;
   logic [pfst_pkg::DIST_W-1:0]           threshold;

   logic [pfst_pkg::ANGLE_U_W-1:0] start_u;
   logic [pfst_pkg::ANGLE_U_W-1:0] end_u;
   logic [pfst_pkg::ANGLE_U_W-1:0] span;
   logic [pfst_pkg::ANGLE_U_W-1:0] span_q;
   logic [pfst_pkg::ANGLE_U_W-1:0] span_r;
   logic [pfst_pkg::PROD_W-1:0]    prod;
   logic [pfst_pkg::SLOT_W-1:0]    start_slot;
   logic [pfst_pkg::SLOT_W-1:0]    end_slot;
   logic                           angles_ok;
   logic                           index_ok;

   assign opcode         = req_tuser;
   assign slot_index     = req_tdata[5:0];
   assign distance_value = req_tdata[21:6];
   assign start_angle    = req_tdata[34:22];
   assign end_angle      = req_tdata[47:35];
   assign threshold      = req_tdata[63:48];

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      start_u    = start_angle[pfst_pkg::ANGLE_U_W-1:0];
      end_u      = end_angle[pfst_pkg::ANGLE_U_W-1:0];
      angles_ok  = pfst_pkg::angle_ok(start_angle) && pfst_pkg::angle_ok(end_angle);
      index_ok   = ({1'b0, slot_index} < (pfst_pkg::IDX_W + 1)'(pfst_pkg::NUM_SLOTS));
      start_slot = pfst_pkg::angle_slot(start_u);
      end_slot   = pfst_pkg::angle_slot(end_u);
      span       = end_u - start_u;
      prod       = pfst_pkg::PROD_W'(span) * pfst_pkg::PROD_W'(pfst_pkg::RECIP_TEN);
      span_q     = pfst_pkg::ANGLE_U_W'(prod >> pfst_pkg::RECIP_SHIFT);
      span_r     = span - ((span_q << 3) + (span_q << 1));

      cmd.kind      = pfst_pkg::K_NONE;
      cmd.bad       = 1'b0;
      cmd.slot_lo   = pfst_pkg::SLOT_W'(slot_index);
      cmd.slot_hi   = end_slot;
      cmd.angle     = start_u;
      cmd.q0        = span_q;
      cmd.r0        = pfst_pkg::REM_W'(span_r);
      cmd.distance  = distance_value;
      cmd.threshold = threshold;

      case (opcode)
         pfst_pkg::OP_WRITE: begin
            if (index_ok) begin
               cmd.kind = pfst_pkg::K_WRITE;
            end else begin
               cmd.bad = 1'b1;
            end
         end
         pfst_pkg::OP_READ: begin
            if (index_ok) begin
               cmd.kind = pfst_pkg::K_READ;
            end else begin
               cmd.bad = 1'b1;
            end
         end
         pfst_pkg::OP_CLEAR: begin
            cmd.kind = pfst_pkg::K_CLEAR;
         end
         pfst_pkg::OP_SEARCH: begin
            cmd.slot_lo = start_slot;
            if (!angles_ok) begin
               cmd.bad = 1'b1;
            end else if (start_slot <= end_slot) begin
               cmd.kind = pfst_pkg::K_SEARCH;
            end
         end
         pfst_pkg::OP_OCCUPY: begin
            if (!angles_ok) begin
               cmd.bad = 1'b1;
            end else if (start_u < end_u) begin
               cmd.kind = pfst_pkg::K_OCCUPY;
            end
         end
         default: begin
            cmd.kind = pfst_pkg::K_NONE;
         end
      endcase
   end

endmodule

FILE: rtl/pfst_fifo.sv
// Short command queue between the front end and the back end.
// Holds pfst_pkg::cmd_type entries; depth from pfst_pkg::QUEUE_DEPTH.
module pfst_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pfst_pkg::cmd_type push_data,
   input  logic              pop,
   output pfst_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);

   pfst_pkg::cmd_type              entry_ff [pfst_pkg::QUEUE_DEPTH];
   logic [pfst_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [pfst_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [pfst_pkg::QCNT_W-1:0]    count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == pfst_pkg::QCNT_W'(pfst_pkg::QUEUE_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == pfst_pkg::QPTR_W'(pfst_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + pfst_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == pfst_pkg::QPTR_W'(pfst_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + pfst_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + pfst_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - pfst_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/pfst_back.sv
// Back end: runs one command at a time against the slot memory and holds the response.
// Uses pfst_pkg and instantiates pfst_ram for the slot distances.
module pfst_back (
   input  logic                            clock,
   input  logic                            reset,
   input  pfst_pkg::cmd_type               cmd_head,
   input  logic                            cmd_empty,
   output logic                            cmd_pop,
   input  logic [pfst_pkg::DIST_W-1:0]     max_distance,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pfst_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   pfst_pkg::back_state_type state_ff, state_in;
   pfst_pkg::cmd_type        cmd_ff, cmd_in;

   logic [pfst_pkg::SLOT_W-1:0]     addr_ff, addr_in;
   logic [pfst_pkg::ANGLE_U_W-1:0]  ang_ff, ang_in;
   logic [pfst_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [pfst_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                            rd_pend_ff, rd_pend_in;
   logic [pfst_pkg::SLOT_W-1:0]     rd_slot_ff, rd_slot_in;
   logic [pfst_pkg::DIST_W-1:0]     dist_ff, dist_in;
   logic [pfst_pkg::SLOT_W-1:0]     best_slot_ff, best_slot_in;
   logic                            found_ff, found_in;
   logic                            occ_ff, occ_in;
   logic [pfst_pkg::NUM_SLOTS-1:0]  valid_ff, valid_in;
   logic [pfst_pkg::DIST_W-1:0]     fill_ff, fill_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [pfst_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                            ram_we;
   logic                            issue;
   logic                            last_issue;
   logic                            do_clear;
   logic                            load_rsp;
   logic [pfst_pkg::SLOT_W-1:0]     issue_addr;
   logic [pfst_pkg::DIST_W-1:0]     ram_rd_data;
   logic [pfst_pkg::DIST_W-1:0]     rd_value;
   logic [pfst_pkg::REM_W:0]        rem_sum;
   logic                            rem_wrap;

   pfst_ram #(
      .WIDTH (pfst_pkg::DIST_W),
      .DEPTH (pfst_pkg::NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cmd_ff.slot_lo),
      .wr_data (cmd_ff.distance),
      .rd_en   (issue),
      .rd_addr (issue_addr),
      .rd_data (ram_rd_data)
   );

   // control outputs
   always_comb begin
      cmd_pop    = 1'b0;
      ram_we     = 1'b0;
      do_clear   = 1'b0;
      issue      = 1'b0;
      load_rsp   = 1'b0;
      issue_addr = (cmd_ff.kind == pfst_pkg::K_OCCUPY) ? pfst_pkg::angle_slot(ang_ff) : addr_ff;
      last_issue = (cmd_ff.kind == pfst_pkg::K_READ) ||
                   ((cmd_ff.kind == pfst_pkg::K_SEARCH) && (addr_ff == cmd_ff.slot_hi)) ||
                   ((cmd_ff.kind == pfst_pkg::K_OCCUPY) &&
                    (cnt_ff == pfst_pkg::CNT_W'(pfst_pkg::SAMPLES - 1)));
      case (state_ff)
         pfst_pkg::B_IDLE: begin
            cmd_pop = !cmd_empty;
         end
         pfst_pkg::B_EXEC: begin
            ram_we   = (cmd_ff.kind == pfst_pkg::K_WRITE);
            do_clear = (cmd_ff.kind == pfst_pkg::K_CLEAR);
         end
         pfst_pkg::B_SCAN: begin
            issue = 1'b1;
         end
         pfst_pkg::B_DONE: begin
            load_rsp = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfst_pkg::B_IDLE: begin
            if (!cmd_empty) begin
               state_in = pfst_pkg::B_EXEC;
            end
         end
         pfst_pkg::B_EXEC: begin
            if ((cmd_ff.kind == pfst_pkg::K_READ) || (cmd_ff.kind == pfst_pkg::K_SEARCH) ||
                (cmd_ff.kind == pfst_pkg::K_OCCUPY)) begin
               state_in = pfst_pkg::B_SCAN;
            end else begin
               state_in = pfst_pkg::B_DONE;
            end
         end
         pfst_pkg::B_SCAN: begin
            if (last_issue) begin
               state_in = pfst_pkg::B_DRAIN;
            end
         end
         pfst_pkg::B_DRAIN: begin
            state_in = pfst_pkg::B_DONE;
         end
         pfst_pkg::B_DONE: begin
            if (load_rsp) begin
               state_in = pfst_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = pfst_pkg::B_IDLE;
         end
      endcase
   end

   // datapath
   always_comb begin
      rd_value = valid_ff[rd_slot_ff] ? ram_rd_data : fill_ff;
      rem_sum  = (pfst_pkg::REM_W + 1)'(rem_ff) + (pfst_pkg::REM_W + 1)'(cmd_ff.r0);
      rem_wrap = (rem_sum >= (pfst_pkg::REM_W + 1)'(pfst_pkg::DIVISOR));

      cmd_in       = cmd_pop ? cmd_head : cmd_ff;
      addr_in      = addr_ff;
      ang_in       = ang_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rd_pend_in   = issue;
      rd_slot_in   = issue ? issue_addr : rd_slot_ff;
      dist_in      = dist_ff;
      best_slot_in = best_slot_ff;
      found_in     = found_ff;
      occ_in       = occ_ff;
      valid_in     = valid_ff;
      fill_in      = fill_ff;

      if (cmd_pop) begin
         addr_in      = cmd_head.slot_lo;
         ang_in       = cmd_head.angle;
         rem_in       = '0;
         cnt_in       = '0;
         dist_in      = '0;
         best_slot_in = '0;
         found_in     = 1'b0;
         occ_in       = 1'b0;
      end else if (issue) begin
         addr_in = addr_ff + pfst_pkg::SLOT_W'(1);
         cnt_in  = cnt_ff + pfst_pkg::CNT_W'(1);
         if (rem_wrap) begin
            ang_in = ang_ff + cmd_ff.q0 + pfst_pkg::ANGLE_U_W'(1);
            rem_in = pfst_pkg::REM_W'(rem_sum - (pfst_pkg::REM_W + 1)'(pfst_pkg::DIVISOR));
         end else begin
            ang_in = ang_ff + cmd_ff.q0;
            rem_in = pfst_pkg::REM_W'(rem_sum);
         end
      end

      if (rd_pend_ff) begin
         case (cmd_ff.kind)
            pfst_pkg::K_READ: begin
               dist_in = rd_value;
            end
            pfst_pkg::K_SEARCH: begin
               if (rd_value > dist_ff) begin
                  dist_in      = rd_value;
                  best_slot_in = rd_slot_ff;
                  found_in     = 1'b1;
               end
            end
            pfst_pkg::K_OCCUPY: begin
               if (rd_value < cmd_ff.threshold) begin
                  occ_in = 1'b1;
               end
            end
            default: begin
               dist_in = dist_ff;
            end
         endcase
      end

      if (do_clear) begin
         valid_in = '0;
         fill_in  = max_distance;
      end else if (ram_we) begin
         valid_in[cmd_ff.slot_lo] = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {cmd_ff.bad, occ_ff, found_ff,
                         pfst_pkg::RES_SLOT_W'(best_slot_ff), dist_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfst_pkg::B_IDLE;
         rd_pend_ff   <= 1'b0;
         valid_ff     <= '0;
         fill_ff      <= pfst_pkg::DIST_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         valid_ff     <= valid_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      addr_ff      <= addr_in;
      ang_ff       <= ang_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      rd_slot_ff   <= rd_slot_in;
      dist_ff      <= dist_in;
      best_slot_ff <= best_slot_in;
      found_ff     <= found_in;
      occ_ff       <= occ_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/polar_free_space_table_core.sv
// Top level of the polar free-space table: config register, front end, queue, back end.
// Depends on pfst_pkg, pfst_front, pfst_fifo, pfst_back (which uses pfst_ram).
//
// Usage:
//   req_* carries one request: opcode in req_tuser, arguments in req_tdata.
//   rsp_* returns exactly one response per request, in request order.
//   csr_* writes max_distance, the value the clear operation puts in every slot;
//   csr_ready is always high; write only while no request is in flight.
// Operation:
//   The back end runs one request at a time. A read makes one slot memory read, a
//   range search reads every slot from the start slot to the end slot, up to all 32,
//   and an occupancy test reads the slots of 10 sample angles; write, clear and
//   argument errors read no slot.
//   The scans are paced by the one-read-per-cycle port of the slot memory.
//   A two-entry queue lets the front end take requests while the back end works.
// Reset:
//   Synchronous, active high; every slot reads as 65535 afterwards, with no
//   clearing pass (per-slot valid bits select the fill value until written).
// Backpressure:
//   A stalled response holds in its register; the back end waits for it to drain
//   and req_tready drops once the queue is full.
module polar_free_space_table_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // slot_index, distance_value, start_angle, end_angle, threshold
   input  logic [pfst_pkg::REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic [pfst_pkg::OPCODE_W-1:0]   req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // result_distance, result_slot, slot_found, occupied, bad_argument
   output logic [pfst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pfst_pkg::DIST_W-1:0]     csr_wdata
);

   logic [pfst_pkg::DIST_W-1:0] max_distance_ff, max_distance_in;

   pfst_pkg::cmd_type front_cmd;
   pfst_pkg::cmd_type queue_head;
   logic              push;
   logic              pop;
   logic              queue_empty;
   logic              queue_full;

   assign csr_ready       = 1'b1;
   assign max_distance_in = (csr_valid && csr_ready) ? csr_wdata : max_distance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_distance_ff <= pfst_pkg::DIST_RESET;
      end else begin
         max_distance_ff <= max_distance_in;
      end
   end

   pfst_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (front_cmd)
   );

   pfst_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cmd),
      .pop       (pop),
      .head      (queue_head),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   pfst_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_head     (queue_head),
      .cmd_empty    (queue_empty),
      .cmd_pop      (pop),
      .max_distance (max_distance_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

FILE: rtl/pfst_checker.sv
// Port-level checks on the response channel of the polar free-space table.
// Depends on pfst_pkg; bound to polar_free_space_table_core below.
module pfst_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pfst_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed or dropped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23] |-> (rsp_tdata[22:0] == 23'd0))
      else $error("bad argument response carries nonzero fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[21] |-> (rsp_tdata[20:16] == 5'd0))
      else $error("slot reported without a found slot");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21] |-> (rsp_tdata[15:0] != 16'd0) && !rsp_tdata[22])
      else $error("found slot with zero distance or occupancy flag");

endmodule

bind polar_free_space_table_core pfst_checker u_pfst_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for polar_free_space_table_core: directed requests, then
// random phases under changing max_distance and idle patterns. Depends on pfst_pkg.
module tb;
   import pfst_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SPARE_MID   = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int PHASES          = 6;
   localparam int PHASE_ITEMS     = 175;
   localparam int DRAIN_CYCLES    = 40;

   typedef struct packed {
      logic [OPCODE_W-1:0]       op;
      logic [IDX_W-1:0]          idx;
      logic [DIST_W-1:0]         distance;
      logic signed [ANGLE_W-1:0] sa;
      logic signed [ANGLE_W-1:0] ea;
      logic [DIST_W-1:0]         thr;
   } table_req_type;

   typedef struct packed {
      logic [DIST_W-1:0]     distance;
      logic [RES_SLOT_W-1:0] slot;
      logic                  found;
      logic                  occupied;
      logic                  bad;
   } table_rsp_type;

   typedef struct {
      table_req_type req;
      bit            typed;
      table_rsp_type rsp;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OPCODE_W-1:0]   req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [DIST_W-1:0]     csr_wdata = '0;

   logic [DIST_W-1:0] free_dist [NUM_SLOTS];
   logic [DIST_W-1:0] clear_dist;
   table_rsp_type     pending_rsp [$];
   table_rsp_type     oldest_rsp;
   directed_row_type  directed_rows [$];
   int                fail_count = 0;
   int                idle_cycles = 0;
   int                req_idle_pct = 0;
   int                rsp_idle_pct = 0;
   bit                rsp_hold_request = 1'b0;

   polar_free_space_table_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit in_span(input int a);
      return a >= 0 && a <= ANGLE_MAX;
   endfunction

   function automatic int slot_of(input int a);
      int s;
      if (a <= 0) begin
         return 0;
      end
      s = (a - 1) >> FRAC_BITS;
      if (s >= NUM_SLOTS) begin
         s = NUM_SLOTS - 1;
      end
      return s;
   endfunction

   function automatic table_rsp_type apply_table_op(input table_req_type r);
      table_rsp_type o;
      int sa_i, ea_i, lo, hi, i, k, a, span;
      logic [DIST_W-1:0] best;
      o = '0;
      sa_i = int'($signed(r.sa));
      ea_i = int'($signed(r.ea));
      case (r.op)
         OP_WRITE: begin
            if (r.idx < NUM_SLOTS) free_dist[r.idx] = r.distance;
            else o.bad = 1'b1;
         end
         OP_READ: begin
            if (r.idx < NUM_SLOTS) o.distance = free_dist[r.idx];
            else o.bad = 1'b1;
         end
         OP_CLEAR: begin
            for (i = 0; i < NUM_SLOTS; i++) free_dist[i] = clear_dist;
         end
         OP_SEARCH: begin
            if (!in_span(sa_i) || !in_span(ea_i)) begin
               o.bad = 1'b1;
            end else begin
               lo = slot_of(sa_i);
               hi = slot_of(ea_i);
               best = '0;
               for (i = lo; i <= hi && i < NUM_SLOTS; i++) begin
                  if (free_dist[i] > best) begin
                     best = free_dist[i];
                     o.slot = RES_SLOT_W'(i);
                     o.found = 1'b1;
                  end
               end
               if (o.found) o.distance = best;
            end
         end
         OP_OCCUPY: begin
            if (!in_span(sa_i) || !in_span(ea_i)) begin
               o.bad = 1'b1;
            end else if (sa_i < ea_i) begin
               span = ea_i - sa_i;
               for (k = 0; k < SAMPLES; k++) begin
                  a = sa_i + (k * span) / DIVISOR;
                  if (free_dist[slot_of(a)] < r.thr) o.occupied = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   function automatic logic [ANGLE_W-1:0] random_angle();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         return ANGLE_W'($urandom);
      end
      if (pick < 35) begin
         return ANGLE_W'($urandom_range(NUM_SLOTS) * (1 << FRAC_BITS) + $urandom_range(2) - 1);
      end
      return ANGLE_W'($urandom_range(ANGLE_MAX));
   endfunction

   function automatic table_req_type random_request();
      table_req_type r;
      logic [ANGLE_W-1:0] swap;
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) r.op = OP_WRITE;
      else if (pick < 48) r.op = OP_READ;
      else if (pick < 53) r.op = OP_CLEAR;
      else if (pick < 73) r.op = OP_SEARCH;
      else if (pick < 93) r.op = OP_OCCUPY;
      else r.op = OPCODE_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      r.idx = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(63, NUM_SLOTS))
                                       : IDX_W'($urandom_range(NUM_SLOTS - 1));
      pick = $urandom_range(9);
      if (pick == 0) r.distance = '0;
      else if (pick == 1) r.distance = '1;
      else if (pick < 4) r.distance = DIST_W'($urandom_range(3));
      else r.distance = DIST_W'($urandom);
      r.sa = random_angle();
      r.ea = random_angle();
      if ((r.op == OP_SEARCH || r.op == OP_OCCUPY) && $urandom_range(9) < 8
          && $signed(r.sa) > $signed(r.ea)) begin
         swap = r.sa;
         r.sa = r.ea;
         r.ea = swap;
      end
      r.thr = ($urandom_range(9) < 4) ? DIST_W'($urandom_range(255)) : DIST_W'($urandom);
      return r;
   endfunction

   task automatic add_row(input logic [OPCODE_W-1:0] op, input int idx, input int distance,
                          input int sa, input int ea, input int thr, input bit typed,
                          input int e_dist, input bit e_bad);
      directed_row_type row;
      row.req.op = op;
      row.req.idx = IDX_W'(idx);
      row.req.distance = DIST_W'(distance);
      row.req.sa = ANGLE_W'(sa);
      row.req.ea = ANGLE_W'(ea);
      row.req.thr = DIST_W'(thr);
      row.typed = typed;
      row.rsp = '0;
      row.rsp.distance = DIST_W'(e_dist);
      row.rsp.bad = e_bad;
      directed_rows.push_back(row);
   endtask

   task automatic send_request(input table_req_type r, input bit typed,
                               input table_rsp_type typed_rsp);
      table_rsp_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.op;
      req_tdata <= {r.thr, r.ea, r.sa, r.distance, r.idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_table_op(r);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic write_max_distance(input logic [DIST_W-1:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      clear_dist = v;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_all_responses();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_tdata);
            fail_count++;
         end else begin
            oldest_rsp = pending_rsp.pop_front();
            if (rsp_tdata[15:0] !== oldest_rsp.distance) begin
               $error("result_distance expected %0d got %0d", oldest_rsp.distance,
                      rsp_tdata[15:0]);
               fail_count++;
            end
            if (rsp_tdata[20:16] !== oldest_rsp.slot) begin
               $error("result_slot expected %0d got %0d", oldest_rsp.slot, rsp_tdata[20:16]);
               fail_count++;
            end
            if (rsp_tdata[21] !== oldest_rsp.found) begin
               $error("slot_found expected %0d got %0d", oldest_rsp.found, rsp_tdata[21]);
               fail_count++;
            end
            if (rsp_tdata[22] !== oldest_rsp.occupied) begin
               $error("occupied expected %0d got %0d", oldest_rsp.occupied, rsp_tdata[22]);
               fail_count++;
            end
            if (rsp_tdata[23] !== oldest_rsp.bad) begin
               $error("bad_argument expected %0d got %0d", oldest_rsp.bad, rsp_tdata[23]);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int i, phase;
      logic [DIST_W-1:0] cfg;
      clear_dist = DIST_RESET;
      for (i = 0; i < NUM_SLOTS; i++) free_dist[i] = DIST_RESET;

      add_row(OP_READ, 0, 0, 0, 0, 0, 1, 65535, 0);
      add_row(OP_READ, NUM_SLOTS - 1, 0, 0, 0, 0, 1, 65535, 0);
      add_row(OP_READ, NUM_SLOTS, 0, 0, 0, 0, 1, 0, 1);
      add_row(OP_READ, 63, 0, 0, 0, 0, 1, 0, 1);
      add_row(OP_WRITE, 63, 65535, 0, 0, 0, 1, 0, 1);
      add_row(OP_WRITE, 0, 0, 0, 0, 0, 1, 0, 0);
      add_row(OP_WRITE, NUM_SLOTS - 1, 65535, 0, 0, 0, 1, 0, 0);
      add_row(OP_WRITE, 1, 65535, 0, 0, 0, 1, 0, 0);
      add_row(OP_READ, 0, 0, 0, 0, 0, 1, 0, 0);
      add_row(OP_SEARCH, 0, 0, 0, ANGLE_MAX, 0, 0, 0, 0);
      add_row(OP_SEARCH, 0, 0, -1, ANGLE_MAX, 0, 1, 0, 1);
      add_row(OP_SEARCH, 0, 0, 0, ANGLE_MAX + 1, 0, 1, 0, 1);
      add_row(OP_SEARCH, 0, 0, -4096, 4095, 0, 1, 0, 1);
      add_row(OP_SEARCH, 0, 0, ANGLE_MAX, 0, 0, 0, 0, 0);
      add_row(OP_SEARCH, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_SEARCH, 0, 0, 64, 65, 0, 0, 0, 0);
      add_row(OP_OCCUPY, 0, 0, 0, ANGLE_MAX, 65535, 0, 0, 0);
      add_row(OP_OCCUPY, 0, 0, 100, 100, 65535, 1, 0, 0);
      add_row(OP_OCCUPY, 0, 0, ANGLE_MAX, 0, 65535, 1, 0, 0);
      add_row(OP_OCCUPY, 0, 0, 0, 4095, 65535, 1, 0, 1);
      add_row(OP_OCCUPY, 0, 0, 0, ANGLE_MAX, 0, 1, 0, 0);
      add_row(OP_SPARE_FIRST, 5, 1234, 200, 300, 77, 1, 0, 0);
      add_row(OP_SPARE_MID, 63, 65535, -4096, 4095, 65535, 1, 0, 0);
      add_row(OP_SPARE_LAST, 31, 42, 0, ANGLE_MAX, 1, 1, 0, 0);
      add_row(OP_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0);
      add_row(OP_READ, 0, 0, 0, 0, 0, 1, 65535, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[j]) begin
         send_request(directed_rows[j].req, directed_rows[j].typed, directed_rows[j].rsp);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         wait_all_responses();
         case (phase)
            0: cfg = '0;
            1: cfg = '1;
            3: cfg = DIST_W'(1);
            5: cfg = DIST_W'(16'hFFFE);
            default: cfg = DIST_W'($urandom);
         endcase
         write_max_distance(cfg);
         if (phase < 2) begin
            req_idle_pct = 7;
            rsp_idle_pct = 77;
         end else if (phase < 4) begin
            req_idle_pct = 77;
            rsp_idle_pct = 7;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (phase == 1) rsp_hold_request = 1'b1;
         repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, '0);
      end

      wait_all_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
